### sv/hsop_pkg.sv
`default_nettype none

package hsop_pkg;

	// request codes
	localparam logic [1:0] REQ_ORDER   = 2'd0;
	localparam logic [1:0] REQ_SUCCESS = 2'd1;
	localparam logic [1:0] REQ_CLEAR   = 2'd2;

	// policy codes
	localparam logic [1:0] MODE_SEQ = 2'd0;
	localparam logic [1:0] MODE_RR  = 2'd1;
	localparam logic [1:0] MODE_LU  = 2'd2;

	// configuration register indexes
	localparam int CFG_IW = 1;
	localparam int CFG_DW = 4;
	localparam logic [CFG_IW-1:0] REG_POLICY_MODE  = 1'd0;
	localparam logic [CFG_IW-1:0] REG_TARGET_COUNT = 1'd1;

	// input and result items
	typedef struct packed {
		logic [1:0] req_type;
		logic [3:0] success_index;
	} in_item_t;

	typedef struct packed {
		logic [2:0] target_index;
		logic       use_default;
		logic       last;
	} out_item_t;

	// datapath operations
	typedef enum logic [4:0] {
		OP_IDLE,
		OP_NOP,
		OP_START,
		OP_REDUCE,
		OP_EMIT_IDX,
		OP_CUR_ADV,
		OP_EMIT_DFLT,
		OP_CNT_RD,
		OP_CNT_INC,
		OP_CLEAR,
		OP_FILL_RD,
		OP_FILL_WR,
		OP_I_RESET,
		OP_RD_I,
		OP_LOAD_CUR,
		OP_CMP_J,
		OP_WR_I,
		OP_RD_E,
		OP_EMIT_LU
	} uop_t;

	// jump conditions
	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_ITEM,
		C_REQ_SUCC,
		C_REQ_CLR,
		C_REQ_BAD,
		C_N_ZERO,
		C_N_ONE,
		C_MODE_LU,
		C_START_GE_N,
		C_STAY_EMIT,
		C_OUT_WAIT,
		C_I1_LT_N,
		C_I2_LT_N,
		C_J1_LT_N
	} cond_t;

	localparam int PC_W = 5;

	// program step addresses
	localparam logic [PC_W-1:0] U_IDLE      = 5'd0;
	localparam logic [PC_W-1:0] U_DISP_SUCC = 5'd1;
	localparam logic [PC_W-1:0] U_DISP_CLR  = 5'd2;
	localparam logic [PC_W-1:0] U_DISP_BAD  = 5'd3;
	localparam logic [PC_W-1:0] U_DISP_ZERO = 5'd4;
	localparam logic [PC_W-1:0] U_START     = 5'd5;
	localparam logic [PC_W-1:0] U_REDUCE    = 5'd6;
	localparam logic [PC_W-1:0] U_EMIT_IDX  = 5'd7;
	localparam logic [PC_W-1:0] U_CUR_ADV   = 5'd8;
	localparam logic [PC_W-1:0] U_DFLT      = 5'd9;
	localparam logic [PC_W-1:0] U_DFLT_DONE = 5'd10;
	localparam logic [PC_W-1:0] U_CNT_RD    = 5'd11;
	localparam logic [PC_W-1:0] U_CNT_INC   = 5'd12;
	localparam logic [PC_W-1:0] U_CLEAR     = 5'd13;
	localparam logic [PC_W-1:0] U_FILL_RD   = 5'd14;
	localparam logic [PC_W-1:0] U_FILL_WR   = 5'd15;
	localparam logic [PC_W-1:0] U_SORT_INIT = 5'd16;
	localparam logic [PC_W-1:0] U_OUTER     = 5'd17;
	localparam logic [PC_W-1:0] U_LOAD_CUR  = 5'd18;
	localparam logic [PC_W-1:0] U_INNER     = 5'd19;
	localparam logic [PC_W-1:0] U_WR_I      = 5'd20;
	localparam logic [PC_W-1:0] U_EMIT_INIT = 5'd21;
	localparam logic [PC_W-1:0] U_RD_E      = 5'd22;
	localparam logic [PC_W-1:0] U_EMIT_LU   = 5'd23;
	localparam logic [PC_W-1:0] U_LU_DONE   = 5'd24;

	// one control word per step
	typedef struct packed {
		uop_t            op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ctrl_t;

	// status from the datapath for jump decisions
	typedef struct packed {
		logic item_acc;
		logic req_succ;
		logic req_clr;
		logic req_bad;
		logic n_zero;
		logic n_one;
		logic mode_lu;
		logic start_ge_n;
		logic out_wait;
		logic i1_lt_n;
		logic i2_lt_n;
		logic j1_lt_n;
	} flags_t;

	// control store
	function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] pc);
		ctrl_t w;
		unique case (pc)
			U_IDLE:      w = '{OP_IDLE,      C_NO_ITEM,    U_IDLE};
			U_DISP_SUCC: w = '{OP_NOP,       C_REQ_SUCC,   U_CNT_RD};
			U_DISP_CLR:  w = '{OP_NOP,       C_REQ_CLR,    U_CLEAR};
			U_DISP_BAD:  w = '{OP_NOP,       C_REQ_BAD,    U_IDLE};
			U_DISP_ZERO: w = '{OP_NOP,       C_N_ZERO,     U_DFLT};
			U_START:     w = '{OP_START,     C_MODE_LU,    U_FILL_RD};
			U_REDUCE:    w = '{OP_REDUCE,    C_START_GE_N, U_REDUCE};
			U_EMIT_IDX:  w = '{OP_EMIT_IDX,  C_STAY_EMIT,  U_EMIT_IDX};
			U_CUR_ADV:   w = '{OP_CUR_ADV,   C_ALWAYS,     U_IDLE};
			U_DFLT:      w = '{OP_EMIT_DFLT, C_OUT_WAIT,   U_DFLT};
			U_DFLT_DONE: w = '{OP_NOP,       C_ALWAYS,     U_IDLE};
			U_CNT_RD:    w = '{OP_CNT_RD,    C_NEVER,      U_IDLE};
			U_CNT_INC:   w = '{OP_CNT_INC,   C_ALWAYS,     U_IDLE};
			U_CLEAR:     w = '{OP_CLEAR,     C_ALWAYS,     U_IDLE};
			U_FILL_RD:   w = '{OP_FILL_RD,   C_NEVER,      U_IDLE};
			U_FILL_WR:   w = '{OP_FILL_WR,   C_I1_LT_N,    U_FILL_WR};
			U_SORT_INIT: w = '{OP_I_RESET,   C_N_ONE,      U_RD_E};
			U_OUTER:     w = '{OP_RD_I,      C_NEVER,      U_IDLE};
			U_LOAD_CUR:  w = '{OP_LOAD_CUR,  C_NEVER,      U_IDLE};
			U_INNER:     w = '{OP_CMP_J,     C_J1_LT_N,    U_INNER};
			U_WR_I:      w = '{OP_WR_I,      C_I2_LT_N,    U_OUTER};
			U_EMIT_INIT: w = '{OP_I_RESET,   C_NEVER,      U_IDLE};
			U_RD_E:      w = '{OP_RD_E,      C_NEVER,      U_IDLE};
			U_EMIT_LU:   w = '{OP_EMIT_LU,   C_STAY_EMIT,  U_EMIT_LU};
			U_LU_DONE:   w = '{OP_NOP,       C_ALWAYS,     U_IDLE};
			default:     w = '{OP_NOP,       C_ALWAYS,     U_IDLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

### sv/host_selection_order_policy_core.sv
// channel   signals                          item type
// request   req_valid / req_stall / req_item  hsop_pkg::in_item_t
// result    rsp_valid / rsp_stall / rsp_item  hsop_pkg::out_item_t
// config    cfg_we / cfg_index / cfg_data     write only
//
// one item at a time, stepped by a microcode program over a count ram and a sort ram
// order request, sequential or round robin: the start is reduced below n, then one result per target
// order request, least used: counts are copied to the sort ram, sorted with one compare per cycle, then emitted
// success report and clear: no result; no targets: a single default result
// reset clears counts (valid bits), cursor and registers at once, no clearing pass
// a stalled result holds the sequencer in its emit step; results leave one per cycle
`default_nettype none

module host_selection_order_policy_core #(
	parameter int MAX_TARGETS = 8,
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_stall,
	input  wire hsop_pkg::in_item_t          req_item,
	output logic                             rsp_valid,
	input  wire logic                        rsp_stall,
	output hsop_pkg::out_item_t              rsp_item,
	input  wire logic                        cfg_we,
	input  wire logic [hsop_pkg::CFG_IW-1:0] cfg_index,
	input  wire logic [hsop_pkg::CFG_DW-1:0] cfg_data
);

	hsop_pkg::ctrl_t  ctrl;
	hsop_pkg::flags_t flags;

	// program sequencer
	hsop_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	// datapath with count and sort memories
	hsop_dp #(
		.MAX_TARGETS (MAX_TARGETS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.flags     (flags),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

`default_nettype wire

### sv/hsop_ram.sv
`default_nettype none

module hsop_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### sv/hsop_seq.sv
`default_nettype none

module hsop_seq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire hsop_pkg::flags_t flags,
	output hsop_pkg::ctrl_t       ctrl
);

	logic [hsop_pkg::PC_W-1:0] pc_q;
	logic                      take;

	// fetch the control word of the current step
	assign ctrl = hsop_pkg::ucode_rom(pc_q);

	// jump condition select
	always_comb begin
		unique case (ctrl.cond)
			hsop_pkg::C_NEVER:      take = 1'b0;
			hsop_pkg::C_ALWAYS:     take = 1'b1;
			hsop_pkg::C_NO_ITEM:    take = !flags.item_acc;
			hsop_pkg::C_REQ_SUCC:   take = flags.req_succ;
			hsop_pkg::C_REQ_CLR:    take = flags.req_clr;
			hsop_pkg::C_REQ_BAD:    take = flags.req_bad;
			hsop_pkg::C_N_ZERO:     take = flags.n_zero;
			hsop_pkg::C_N_ONE:      take = flags.n_one;
			hsop_pkg::C_MODE_LU:    take = flags.mode_lu;
			hsop_pkg::C_START_GE_N: take = flags.start_ge_n;
			hsop_pkg::C_STAY_EMIT:  take = flags.out_wait || flags.i1_lt_n;
			hsop_pkg::C_OUT_WAIT:   take = flags.out_wait;
			hsop_pkg::C_I1_LT_N:    take = flags.i1_lt_n;
			hsop_pkg::C_I2_LT_N:    take = flags.i2_lt_n;
			hsop_pkg::C_J1_LT_N:    take = flags.j1_lt_n;
			default:                take = 1'b0;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= hsop_pkg::U_IDLE;
		end else if (take) begin
			pc_q <= ctrl.target;
		end else begin
			pc_q <= pc_q + hsop_pkg::PC_W'(1);
		end
	end

endmodule

`default_nettype wire

### sv/hsop_dp.sv
`default_nettype none

module hsop_dp #(
	parameter int MAX_TARGETS = 8,
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire hsop_pkg::ctrl_t               ctrl,
	output hsop_pkg::flags_t                   flags,
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire hsop_pkg::in_item_t            req_item,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output hsop_pkg::out_item_t                rsp_item,
	input  wire logic                          cfg_we,
	input  wire logic [hsop_pkg::CFG_IW-1:0]   cfg_index,
	input  wire logic [hsop_pkg::CFG_DW-1:0]   cfg_data
);

	localparam int IW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
	localparam int NW = $clog2(MAX_TARGETS + 1);
	localparam int SW = NW + 1;
	localparam int CW = COUNT_WIDTH;
	localparam int EW = IW + CW;

	// configuration and persistent state
	logic [1:0]             mode_q;
	logic [3:0]             tc_q;
	logic [IW-1:0]          cursor_q;
	logic [MAX_TARGETS-1:0] vld_q;
	logic                   cnt_rv_q;

	// working registers
	logic [1:0]             req_q;
	logic [3:0]             succ_q;
	logic [NW-1:0]          i_q;
	logic [NW-1:0]          j_q;
	logic [IW-1:0]          start_q;
	logic [IW-1:0]          cur_idx_q;
	logic [CW-1:0]          cur_cnt_q;
	logic                   rsp_valid_q;
	hsop_pkg::out_item_t    rsp_item_q;

	// memory ports
	logic          cnt_we, cnt_re, srt_we, srt_re;
	logic [IW-1:0] cnt_waddr, cnt_raddr, srt_waddr, srt_raddr;
	logic [CW-1:0] cnt_wdata, cnt_rdata;
	logic [EW-1:0] srt_wdata, srt_rdata;

	// derived values
	logic [NW-1:0]       n;
	logic [SW-1:0]       n_ext, i1, i2, j1, rr_sum, rr_full, start_nxt, start_sub;
	logic [IW-1:0]       rr_idx, s_addr, srt_idx;
	logic [CW-1:0]       cnt_val, cnt_inc, srt_cnt;
	logic                s_ok, mode_rr, mode_lu, out_free, emit, swap, item_acc, is_last;
	hsop_pkg::out_item_t emit_item;

	// per-target use counts, valid bits stand for cleared entries
	hsop_ram #(.WIDTH(CW), .DEPTH(MAX_TARGETS)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cnt_re),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	// working order for the least-used sort, entry is {index, count}
	hsop_ram #(.WIDTH(EW), .DEPTH(MAX_TARGETS)) u_srt_ram (
		.clk   (clk),
		.we    (srt_we),
		.waddr (srt_waddr),
		.wdata (srt_wdata),
		.re    (srt_re),
		.raddr (srt_raddr),
		.rdata (srt_rdata)
	);

	// active target count, saturated
	always_comb begin
		if (32'(tc_q) > MAX_TARGETS) begin
			n = NW'(MAX_TARGETS);
		end else begin
			n = NW'(tc_q);
		end
	end

	// counters and index arithmetic
	assign n_ext     = SW'(n);
	assign i1        = SW'(i_q) + SW'(1);
	assign i2        = SW'(i_q) + SW'(2);
	assign j1        = SW'(j_q) + SW'(1);
	assign rr_sum    = SW'(start_q) + SW'(i_q);
	assign rr_full   = (rr_sum >= n_ext) ? (rr_sum - n_ext) : rr_sum;
	assign rr_idx    = IW'(rr_full);
	assign start_nxt = SW'(start_q) + SW'(1);
	assign start_sub = SW'(start_q) - n_ext;
	assign is_last   = (i1 == n_ext);

	// success report target
	assign s_ok   = 32'(succ_q) < 32'(n);
	assign s_addr = IW'(succ_q);

	// count read with cleared entries as zero, saturating increment
	assign cnt_val = cnt_rv_q ? cnt_rdata : '0;
	assign cnt_inc = (&cnt_val) ? cnt_val : cnt_val + CW'(1);

	// sort entry fields and compare
	assign srt_cnt = srt_rdata[CW-1:0];
	assign srt_idx = srt_rdata[EW-1:CW];
	assign swap    = srt_cnt < cur_cnt_q;

	assign mode_rr = (mode_q == hsop_pkg::MODE_RR);
	assign mode_lu = (mode_q == hsop_pkg::MODE_LU);

	// handshakes
	assign req_stall = (ctrl.op != hsop_pkg::OP_IDLE);
	assign item_acc  = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign emit      = out_free && (ctrl.op == hsop_pkg::OP_EMIT_IDX ||
		ctrl.op == hsop_pkg::OP_EMIT_DFLT || ctrl.op == hsop_pkg::OP_EMIT_LU);
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;

	// status for the sequencer
	always_comb begin
		flags.item_acc   = item_acc;
		flags.req_succ   = (req_q == hsop_pkg::REQ_SUCCESS);
		flags.req_clr    = (req_q == hsop_pkg::REQ_CLEAR);
		flags.req_bad    = (req_q != hsop_pkg::REQ_ORDER);
		flags.n_zero     = (n == '0);
		flags.n_one      = (n_ext == SW'(1));
		flags.mode_lu    = mode_lu;
		flags.start_ge_n = (SW'(start_q) >= n_ext);
		flags.out_wait   = !out_free;
		flags.i1_lt_n    = (i1 < n_ext);
		flags.i2_lt_n    = (i2 < n_ext);
		flags.j1_lt_n    = (j1 < n_ext);
	end

	// memory control per operation
	always_comb begin
		cnt_we    = 1'b0;
		cnt_re    = 1'b0;
		cnt_waddr = s_addr;
		cnt_wdata = cnt_inc;
		cnt_raddr = IW'(i_q);
		srt_we    = 1'b0;
		srt_re    = 1'b0;
		srt_waddr = IW'(i_q);
		srt_wdata = {IW'(i_q), cnt_val};
		srt_raddr = IW'(i_q);
		case (ctrl.op)
			hsop_pkg::OP_CNT_RD: begin
				cnt_re    = 1'b1;
				cnt_raddr = s_addr;
			end
			hsop_pkg::OP_CNT_INC: begin
				cnt_we = s_ok;
			end
			hsop_pkg::OP_FILL_RD: begin
				cnt_re = 1'b1;
			end
			hsop_pkg::OP_FILL_WR: begin
				srt_we    = 1'b1;
				cnt_re    = 1'b1;
				cnt_raddr = IW'(i1);
			end
			hsop_pkg::OP_RD_I, hsop_pkg::OP_RD_E: begin
				srt_re = 1'b1;
			end
			hsop_pkg::OP_LOAD_CUR: begin
				srt_re    = 1'b1;
				srt_raddr = IW'(j_q);
			end
			hsop_pkg::OP_CMP_J: begin
				srt_we    = swap;
				srt_waddr = IW'(j_q);
				srt_wdata = {cur_idx_q, cur_cnt_q};
				srt_re    = 1'b1;
				srt_raddr = IW'(j1);
			end
			hsop_pkg::OP_WR_I: begin
				srt_we    = 1'b1;
				srt_wdata = {cur_idx_q, cur_cnt_q};
			end
			hsop_pkg::OP_EMIT_LU: begin
				srt_re    = out_free;
				srt_raddr = IW'(i1);
			end
			default: begin
			end
		endcase
	end

	// result item to load
	always_comb begin
		emit_item.target_index = 3'(rr_idx);
		emit_item.use_default  = 1'b0;
		emit_item.last         = is_last;
		case (ctrl.op)
			hsop_pkg::OP_EMIT_DFLT: begin
				emit_item.target_index = '0;
				emit_item.use_default  = 1'b1;
				emit_item.last         = 1'b1;
			end
			hsop_pkg::OP_EMIT_LU: begin
				emit_item.target_index = 3'(srt_idx);
			end
			default: begin
			end
		endcase
	end

	// control state: registers, cursor, valid bits, counters, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= hsop_pkg::MODE_SEQ;
			tc_q        <= '0;
			cursor_q    <= '0;
			vld_q       <= '0;
			cnt_rv_q    <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					hsop_pkg::REG_POLICY_MODE:  mode_q <= cfg_data[1:0];
					hsop_pkg::REG_TARGET_COUNT: tc_q   <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cnt_re) begin
				cnt_rv_q <= vld_q[cnt_raddr];
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (ctrl.op)
				hsop_pkg::OP_START, hsop_pkg::OP_I_RESET: begin
					i_q <= '0;
				end
				hsop_pkg::OP_EMIT_IDX, hsop_pkg::OP_EMIT_LU: begin
					if (out_free) begin
						i_q <= NW'(i1);
					end
				end
				hsop_pkg::OP_FILL_WR, hsop_pkg::OP_WR_I: begin
					i_q <= NW'(i1);
				end
				hsop_pkg::OP_RD_I: begin
					j_q <= NW'(i1);
				end
				hsop_pkg::OP_CMP_J: begin
					j_q <= NW'(j1);
				end
				hsop_pkg::OP_CUR_ADV: begin
					if (mode_rr) begin
						cursor_q <= (start_nxt == n_ext) ? '0 : IW'(start_nxt);
					end
				end
				hsop_pkg::OP_CLEAR: begin
					vld_q    <= '0;
					cursor_q <= '0;
				end
				hsop_pkg::OP_CNT_INC: begin
					if (s_ok) begin
						vld_q[s_addr] <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload: latched item, walk start, held sort element, result
	always_ff @(posedge clk) begin
		if (item_acc) begin
			req_q  <= req_item.req_type;
			succ_q <= req_item.success_index;
		end
		if (emit) begin
			rsp_item_q <= emit_item;
		end
		case (ctrl.op)
			hsop_pkg::OP_START: begin
				start_q <= mode_rr ? cursor_q : '0;
			end
			hsop_pkg::OP_REDUCE: begin
				if (SW'(start_q) >= n_ext) begin
					start_q <= IW'(start_sub);
				end
			end
			hsop_pkg::OP_LOAD_CUR: begin
				cur_idx_q <= srt_idx;
				cur_cnt_q <= srt_cnt;
			end
			hsop_pkg::OP_CMP_J: begin
				if (swap) begin
					cur_idx_q <= srt_idx;
					cur_cnt_q <= srt_cnt;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

### sv/hsop_chk.sv
`default_nettype none

module hsop_chk (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                req_valid,
	input wire logic                req_stall,
	input wire hsop_pkg::in_item_t  req_item,
	input wire logic                rsp_valid,
	input wire logic                rsp_stall,
	input wire hsop_pkg::out_item_t rsp_item
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
		else $error("stalled result changed");

	// an accepted item keeps the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("block idle right after accepting an item");

	// a new result comes only out of a busy cycle
	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result appeared without work in progress");

	// the default marker is a single, final result at index zero
	a_default_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_item.use_default |-> rsp_item.last && rsp_item.target_index == 3'd0)
		else $error("malformed default result");

endmodule

bind host_selection_order_policy_core hsop_chk u_hsop_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req_item  (req_item),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_item  (rsp_item)
);

`default_nettype wire
